// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the spline interpolator modules.
// Needs a clock named clk_i and an active-low reset named rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property while out of reset
`define CSI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// check a property on every edge, reset included
`define CSI_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/csi_pkg.sv =====
// Types, constants and codes of the cardinal spline interpolator.
// No dependencies; used by every module of the block.
package csi_pkg;

  localparam int MaxPoints = 256;
  localparam int AddrW     = $clog2(MaxPoints);
  localparam int CountW    = AddrW + 1;
  localparam int CoordW    = 32;
  localparam int TW        = 17;
  localparam int TOne      = 65536;
  localparam int TensW     = 19;
  localparam int KW        = 20;
  localparam int TanW      = 36;
  localparam int WgtW      = 26;
  localparam int AccW      = 64;
  localparam int NLanes    = 3;
  localparam int PointW    = NLanes * CoordW;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [AccW-1:0]   acc_t;
  typedef logic signed [WgtW-1:0]   wgt_t;
  typedef logic signed [KW-1:0]     kfac_t;

  typedef enum logic [2:0] {
    OP_ADD    = 3'd0,
    OP_UPDATE = 3'd1,
    OP_CLEAR  = 3'd2,
    OP_READ   = 3'd3,
    OP_SEG    = 3'd4,
    OP_CURVE  = 3'd5,
    OP_SPARE6 = 3'd6,
    OP_SPARE7 = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_EMPTY = 2'd3
  } st_e;

  localparam logic [2:0] SLOT_P0  = 3'd0;
  localparam logic [2:0] SLOT_PN1 = 3'd1;
  localparam logic [2:0] SLOT_P1  = 3'd2;
  localparam logic [2:0] SLOT_PN2 = 3'd3;
  localparam logic [2:0] SLOT_PM1 = 3'd4;
  localparam logic [2:0] SLOT_PA  = 3'd5;
  localparam logic [2:0] SLOT_PB  = 3'd6;
  localparam logic [2:0] SLOT_PC  = 3'd7;

  typedef enum logic [2:0] {
    LOP_NOP  = 3'd0,
    LOP_TAN1 = 3'd1,
    LOP_TAN2 = 3'd2,
    LOP_M00  = 3'd3,
    LOP_M01  = 3'd4,
    LOP_M10  = 3'd5,
    LOP_M11  = 3'd6
  } lane_op_e;

  typedef enum logic [1:0] {
    EK_ZERO  = 2'd0,
    EK_RAW   = 2'd1,
    EK_CURVE = 2'd2
  } emit_kind_e;

  typedef struct packed {
    wgt_t h00;
    wgt_t h01;
    wgt_t h10;
    wgt_t h11;
  } wgts_t;

  typedef struct packed {
    logic       cap_en;
    logic [2:0] slot;
    lane_op_e   op;
    logic       closed;
    logic       idx_zero;
    logic       seg_last;
  } lane_ctrl_t;

  typedef struct packed {
    logic              valid;
    emit_kind_e        kind;
    st_e               status;
    logic [CountW-1:0] count;
  } emit_t;

  typedef struct packed {
    logic [2:0]        opcode;
    logic [AddrW-1:0]  point_index;
    logic [TW-1:0]     param_t;
    coord_t            coord_x;
    coord_t            coord_y;
    coord_t            coord_z;
  } req_t;

  typedef struct packed {
    coord_t            result_x;
    coord_t            result_y;
    coord_t            result_z;
    logic [1:0]        status;
    logic [CountW-1:0] point_count;
  } res_t;

endpackage

// ===== rtl/cardinal_spline_interpolator.sv =====
// Cardinal spline interpolator: 256-entry point table, one request at a time.
// Table ops and errors finish in the prep state, reads and end-point shortcuts go through
// a fetch state, and a full interpolation runs through a calc state of eight reads from
// the single table port and six steps of each lane's shared multiplier; the result is
// then registered in the merge stage. A new request is taken at the edge ending the strobe.
// Reset empties the table and clears tension; the receiver cannot stall.
module cardinal_spline_interpolator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  csi_pkg::req_t                 req_i,
  input  logic                          cfg_we_i,
  input  logic [csi_pkg::TensW-1:0]     cfg_wdata_i,
  output csi_pkg::res_t                 res_o,
  output logic                          res_strobe_o
);
  import csi_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_PREP  = 4'b0010,
    S_FETCH = 4'b0100,
    S_CALC  = 4'b1000
  } state_e;

  state_e              state_q, state_d;
  req_t                req_q;
  req_t                req_sat;
  logic [24:0]         prod_q;
  logic [CountW-1:0]   count_q, count_d;
  logic [AddrW-1:0]    idx_q, idx_d;
  logic [3:0]          cnt_q, cnt_d;
  logic [TensW-1:0]    tension_q;
  logic [TW-1:0]       t_sat;
  logic [15:0]         u_q, u_d;
  logic [31:0]         t2_q;
  logic [47:0]         t3_q;
  wgts_t               w_q, w_d;
  kfac_t               kfac;

  logic                mem_we;
  logic [AddrW-1:0]    mem_wa, mem_ra;
  logic [PointW-1:0]   mem_q [MaxPoints];
  logic [PointW-1:0]   rd_q;

  logic [AddrW-1:0]    idx_eff;
  logic [TW-1:0]       u_eff;
  st_e                 st;
  emit_t               emit;
  lane_ctrl_t          lctrl;
  acc_t                acc [NLanes];
  logic [NLanes-1:0]   eq;
  logic                closed;

  function automatic wgt_t rnd24(logic signed [51:0] h);
    logic signed [51:0] s;
    s = (h + 52'sd8388608) >>> 24;
    return WgtW'(s);
  endfunction

  assign busy  = (state_q != S_IDLE);
  assign t_sat = (req_i.param_t > TW'(TOne)) ? TW'(TOne) : req_i.param_t;
  assign kfac  = KW'(TOne) - KW'($signed(tension_q));

  always_comb begin
    req_sat         = req_i;
    req_sat.param_t = t_sat;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      cnt_q     <= '0;
      tension_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      cnt_q   <= cnt_d;
      if (cfg_we_i) begin
        tension_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      req_q  <= req_sat;
      prod_q <= 25'(t_sat) * 25'(AddrW'(count_q - 1'b1));
    end
    idx_q <= idx_d;
    u_q   <= u_d;
    t2_q  <= 32'(u_q) * 32'(u_q);
    t3_q  <= 48'(t2_q) * 48'(u_q);
    w_q   <= w_d;
  end

  always_comb begin
    logic signed [51:0] t1s, t2s, t3s;
    t1s = $signed({4'b0, u_q, 32'b0});
    t2s = $signed({4'b0, t2_q, 16'b0});
    t3s = $signed({4'b0, t3_q});
    w_d.h00 = rnd24((t3s <<< 1) - (t2s <<< 1) - t2s + (52'sd1 <<< 48));
    w_d.h01 = rnd24((t2s <<< 1) + t2s - (t3s <<< 1));
    w_d.h10 = rnd24(t3s - (t2s <<< 1) + t1s);
    w_d.h11 = rnd24(t3s - t2s);
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= {req_q.coord_x, req_q.coord_y, req_q.coord_z};
    end
    rd_q <= mem_q[mem_ra];
  end

  always_comb begin
    idx_eff = (req_q.opcode == OP_CURVE) ? prod_q[23:16] : req_q.point_index;
    u_eff   = (req_q.opcode == OP_CURVE) ? {1'b0, prod_q[15:0]} : req_q.param_t;
    st      = ST_OK;
    priority case (req_q.opcode)
      OP_ADD: begin
        if (count_q >= CountW'(MaxPoints)) st = ST_FULL;
      end
      OP_UPDATE, OP_READ, OP_SEG: begin
        if (count_q == '0) begin
          st = ST_EMPTY;
        end else if (CountW'(req_q.point_index) >= count_q) begin
          st = ST_RANGE;
        end
      end
      OP_CURVE: begin
        if (count_q == '0) st = ST_EMPTY;
      end
      default: st = ST_OK;
    endcase
  end

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    cnt_d        = cnt_q;
    idx_d        = idx_q;
    u_d          = u_q;
    mem_we       = 1'b0;
    mem_wa       = count_q[AddrW-1:0];
    mem_ra       = idx_q;
    emit.valid   = 1'b0;
    emit.kind    = EK_ZERO;
    emit.status  = st;
    emit.count   = count_d;
    lctrl.cap_en   = 1'b0;
    lctrl.slot     = cnt_q[2:0] - 3'd1;
    lctrl.op       = LOP_NOP;
    lctrl.closed   = closed;
    lctrl.idx_zero = (idx_q == '0);
    lctrl.seg_last = (CountW'(idx_q) + CountW'(2) == count_q);

    unique case (state_q)
      S_IDLE: begin
        if (start) state_d = S_PREP;
      end
      S_PREP: begin
        idx_d   = idx_eff;
        u_d     = u_eff[15:0];
        cnt_d   = '0;
        state_d = S_IDLE;
        if (st != ST_OK) begin
          emit.valid = 1'b1;
        end else begin
          priority case (req_q.opcode)
            OP_ADD: begin
              mem_we  = 1'b1;
              count_d = count_q + 1'b1;
              emit.valid = 1'b1;
            end
            OP_UPDATE: begin
              mem_we     = 1'b1;
              mem_wa     = req_q.point_index;
              emit.valid = 1'b1;
            end
            OP_CLEAR: begin
              count_d    = '0;
              emit.valid = 1'b1;
            end
            OP_READ: begin
              mem_ra  = idx_eff;
              state_d = S_FETCH;
            end
            OP_SEG, OP_CURVE: begin
              if (CountW'(idx_eff) + CountW'(1) == count_q || u_eff == '0) begin
                mem_ra  = idx_eff;
                state_d = S_FETCH;
              end else if (u_eff[TW-1]) begin
                mem_ra  = idx_eff + 1'b1;
                state_d = S_FETCH;
              end else begin
                state_d = S_CALC;
              end
            end
            default: emit.valid = 1'b1;
          endcase
        end
        emit.count = count_d;
      end
      S_FETCH: begin
        emit.valid = 1'b1;
        emit.kind  = EK_RAW;
        state_d    = S_IDLE;
      end
      S_CALC: begin
        cnt_d = cnt_q + 1'b1;
        unique case (cnt_q[2:0])
          SLOT_P0:  mem_ra = '0;
          SLOT_PN1: mem_ra = AddrW'(count_q - 1'b1);
          SLOT_P1:  mem_ra = AddrW'(1);
          SLOT_PN2: mem_ra = AddrW'(count_q - 2'd2);
          SLOT_PM1: mem_ra = idx_q - 1'b1;
          SLOT_PA:  mem_ra = idx_q;
          SLOT_PB:  mem_ra = idx_q + 1'b1;
          SLOT_PC:  mem_ra = idx_q + 2'd2;
          default:  mem_ra = idx_q;
        endcase
        lctrl.cap_en = (cnt_q >= 4'd1) && (cnt_q <= 4'd8);
        priority case (cnt_q)
          4'd9:    lctrl.op = LOP_TAN1;
          4'd10:   lctrl.op = LOP_TAN2;
          4'd11:   lctrl.op = LOP_M00;
          4'd12:   lctrl.op = LOP_M01;
          4'd13:   lctrl.op = LOP_M10;
          4'd14:   lctrl.op = LOP_M11;
          default: lctrl.op = LOP_NOP;
        endcase
        if (cnt_q == 4'd15) begin
          emit.valid = 1'b1;
          emit.kind  = EK_CURVE;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  for (genvar g = 0; g < NLanes; g++) begin : g_lane
    csi_lane u_lane (
      .clk_i   (clk_i),
      .ctrl_i  (lctrl),
      .coord_i (coord_t'(rd_q[(NLanes-1-g)*CoordW +: CoordW])),
      .k_i     (kfac),
      .wgts_i  (w_q),
      .acc_o   (acc[g]),
      .eq_o    (eq[g])
    );
  end

  csi_merge u_merge (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .emit_i   (emit),
    .raw_i    (rd_q),
    .acc_i    (acc),
    .eq_i     (eq),
    .closed_o (closed),
    .res_o    (res_o),
    .strobe_o (res_strobe_o)
  );

  `include "assert_macros.svh"

  `CSI_ASSERT(a_state_onehot, $onehot(state_q), "state register not one-hot")
  `CSI_ASSERT(a_count_bound, count_q <= CountW'(MaxPoints), "point count above table depth")
  `CSI_ASSERT(a_start_busy, (start && !busy) |=> busy, "request accepted without going busy")
  `CSI_ASSERT(a_strobe_gap, res_strobe_o |=> !res_strobe_o, "result strobe held two cycles")

endmodule

// ===== rtl/csi_lane.sv =====
// One coordinate lane: holds the fetched points, forms tangents and the
// Hermite sum with one shared multiplier. Depends on csi_pkg.
module csi_lane (
  input  logic                clk_i,
  input  csi_pkg::lane_ctrl_t ctrl_i,
  input  csi_pkg::coord_t     coord_i,
  input  csi_pkg::kfac_t      k_i,
  input  csi_pkg::wgts_t      wgts_i,
  output csi_pkg::acc_t       acc_o,
  output logic                eq_o
);
  import csi_pkg::*;

  coord_t                   pts_q [8];
  logic signed [TanW-1:0]   tan1_q, tan1_d, tan2_q, tan2_d, tan_new;
  acc_t                     acc_q, acc_d;
  logic signed [CoordW:0]   d1, d2, d_cl;
  logic signed [TanW-1:0]   mul_a;
  logic signed [WgtW-1:0]   mul_b;
  logic signed [61:0]       prod, prod_rnd;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.cap_en) begin
      pts_q[ctrl_i.slot] <= coord_i;
    end
    tan1_q <= tan1_d;
    tan2_q <= tan2_d;
    acc_q  <= acc_d;
  end

  always_comb begin
    d_cl = (CoordW+1)'(pts_q[SLOT_P1]) - (CoordW+1)'(pts_q[SLOT_PN2]);
    if (ctrl_i.idx_zero) begin
      d1 = ctrl_i.closed ? d_cl
                         : (CoordW+1)'(pts_q[SLOT_P1]) - (CoordW+1)'(pts_q[SLOT_P0]);
    end else begin
      d1 = (CoordW+1)'(pts_q[SLOT_PB]) - (CoordW+1)'(pts_q[SLOT_PM1]);
    end
    if (ctrl_i.seg_last) begin
      d2 = ctrl_i.closed ? d_cl
                         : (CoordW+1)'(pts_q[SLOT_PB]) - (CoordW+1)'(pts_q[SLOT_PA]);
    end else begin
      d2 = (CoordW+1)'(pts_q[SLOT_PC]) - (CoordW+1)'(pts_q[SLOT_PA]);
    end
  end

  always_comb begin
    unique case (ctrl_i.op)
      LOP_NOP: begin
        mul_a = '0;
        mul_b = '0;
      end
      LOP_TAN1: begin
        mul_a = TanW'(d1);
        mul_b = WgtW'(k_i);
      end
      LOP_TAN2: begin
        mul_a = TanW'(d2);
        mul_b = WgtW'(k_i);
      end
      LOP_M00: begin
        mul_a = TanW'(pts_q[SLOT_PA]);
        mul_b = wgts_i.h00;
      end
      LOP_M01: begin
        mul_a = TanW'(pts_q[SLOT_PB]);
        mul_b = wgts_i.h01;
      end
      LOP_M10: begin
        mul_a = tan1_q;
        mul_b = wgts_i.h10;
      end
      LOP_M11: begin
        mul_a = tan2_q;
        mul_b = wgts_i.h11;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod     = 62'(mul_a) * 62'(mul_b);
  assign prod_rnd = prod + 62'sd65536;
  assign tan_new  = TanW'(prod_rnd >>> 17);

  always_comb begin
    tan1_d = (ctrl_i.op == LOP_TAN1) ? tan_new : tan1_q;
    tan2_d = (ctrl_i.op == LOP_TAN2) ? tan_new : tan2_q;
    unique case (ctrl_i.op)
      LOP_M00:                   acc_d = AccW'(prod);
      LOP_M01, LOP_M10, LOP_M11: acc_d = acc_q + AccW'(prod);
      default:                   acc_d = acc_q;
    endcase
  end

  assign acc_o = acc_q;
  assign eq_o  = (pts_q[SLOT_P0] == pts_q[SLOT_PN1]);

endmodule

// ===== rtl/csi_merge.sv =====
// Merge stage: combines the lane flags and registers one result: the three lane sums,
// rounded and saturated, the raw fetched point, or zeros. Depends on csi_pkg.
module csi_merge (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  csi_pkg::emit_t              emit_i,
  input  logic [csi_pkg::PointW-1:0]  raw_i,
  input  csi_pkg::acc_t               acc_i [csi_pkg::NLanes],
  input  logic [csi_pkg::NLanes-1:0]  eq_i,
  output logic                        closed_o,
  output csi_pkg::res_t               res_o,
  output logic                        strobe_o
);
  import csi_pkg::*;

  res_t   res_q, res_d;
  logic   strobe_q;
  coord_t lane_v [NLanes];
  acc_t   rnd [NLanes];

  assign closed_o = &eq_i;

  always_comb begin
    for (int g = 0; g < NLanes; g++) begin
      rnd[g] = (acc_i[g] + 64'sd8388608) >>> 24;
      unique case (emit_i.kind)
        EK_RAW:   lane_v[g] = raw_i[(NLanes-1-g)*CoordW +: CoordW];
        EK_CURVE: begin
          if (rnd[g] > 64'sd2147483647) begin
            lane_v[g] = 32'sh7fffffff;
          end else if (rnd[g] < -64'sd2147483648) begin
            lane_v[g] = 32'sh80000000;
          end else begin
            lane_v[g] = CoordW'(rnd[g]);
          end
        end
        default:  lane_v[g] = '0;
      endcase
    end
    res_d.result_x    = lane_v[0];
    res_d.result_y    = lane_v[1];
    res_d.result_z    = lane_v[2];
    res_d.status      = emit_i.status;
    res_d.point_count = emit_i.count;
  end

  always_ff @(posedge clk_i) begin
    if (emit_i.valid) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= emit_i.valid;
    end
  end

  assign res_o    = res_q;
  assign strobe_o = strobe_q;

endmodule
